// ===== rtl/core/rwvc_pkg.sv =====
// shared item kinds, status codes, register indexes and scan constants
package rwvc_pkg;

  typedef enum logic [1:0] {
    KIND_ADD_EDGE = 2'd0,
    KIND_START    = 2'd1,
    KIND_STEP     = 2'd2,
    KIND_READ     = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_DONE  = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_WALK_LENGTH  = 1'b1;

  localparam int VCOUNT_W = 9;
  localparam int WLEN_W   = 21;
  localparam int VERTEX_W = 8;
  localparam int RAND_W   = 16;
  localparam int OCOUNT_W = 32;

  // adjacency bits examined per scan cycle
  localparam int CHUNK = 8;

endpackage

// ===== rtl/core/random_walk_visit_counter_core.sv =====
// random walk visit counter: adjacency matrix, walk sequencer and visit count store
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | kind_i vertex_a_i vertex_b_i random_value_i
//  out     | from block| out_valid_o / out_stall_i| vertex_o visit_count_o status_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
// after reset a clearing pass over every address zeroes both memories; in_stall_o is high.
// add edge: a read-modify-write of two adjacency rows; read count: a read of the count memory.
// start walk: a sweep of the count memory that zeroes every count but the start vertex's, set to one.
// walk step: the row is scanned 8 bits a cycle for the degree, a restoring remainder
// unit picks the neighbor (with no neighbor in range, a vertex mod the vertex count),
// and a second scan finds it. one request is in flight at a time; a result waiting on
// out_stall_i holds the sequencer in its final state.
module random_walk_visit_counter_core
  import rwvc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COUNT_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [VERTEX_W-1:0] vertex_a_i,
  input  logic [VERTEX_W-1:0] vertex_b_i,
  input  logic [RAND_W-1:0]   random_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VERTEX_W-1:0] vertex_o,
  output logic [OCOUNT_W-1:0] visit_count_o,
  output logic [1:0]          status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [WLEN_W-1:0]   cfg_data_i
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int NCH = (MAX_VERTICES + CHUNK - 1) / CHUNK;
  localparam int PW  = NCH * CHUNK;
  localparam int BW  = $clog2(PW + 1);
  localparam int RW  = NW + 1;
  localparam int KW  = $clog2(CHUNK);
  localparam int PCW = $clog2(CHUNK + 1);
  localparam int IW  = $clog2(RAND_W);

  localparam logic [MAX_VERTICES-1:0] ROW_ONE = 1;
  localparam logic [COUNT_BITS-1:0]   CNT_ONE = 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_E_RD  = 4'd2;
  localparam logic [3:0] S_E_WA  = 4'd3;
  localparam logic [3:0] S_E_WB  = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_DEG   = 4'd6;
  localparam logic [3:0] S_MOD   = 4'd7;
  localparam logic [3:0] S_PICK  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CUSE  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]            state_q, state_d;
  logic [VCOUNT_W-1:0]   vcount_q;
  logic [WLEN_W-1:0]     wlen_q;
  logic [VW-1:0]         cur_q;
  logic [WLEN_W-1:0]     steps_q;
  logic [VERTEX_W-1:0]   a_q, b_q;
  logic [RAND_W-1:0]     dividend_q;
  logic [1:0]            status_q;
  logic [COUNT_BITS-1:0] res_count_q;
  logic                  bump_q;
  logic                  clr_all_q;
  logic [VW-1:0]         clr_addr_q;
  logic [VW-1:0]         rep_q;
  logic [PW-1:0]         row_q;
  logic [BW-1:0]         base_q;
  logic [NW-1:0]         deg_q, seen_q;
  logic [NW-1:0]         div_q;
  logic [RW-1:0]         rem_q;
  logic [IW-1:0]         bit_cnt_q;

  logic                  out_valid_q;
  logic [VERTEX_W-1:0]   vertex_q;
  logic [OCOUNT_W-1:0]   visit_q;
  logic [1:0]            ostat_q;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [COUNT_BITS-1:0]   cnt_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rdata_q;
  logic [COUNT_BITS-1:0]   cnt_rdata_q;

  logic                    adj_we, cnt_we;
  logic [VW-1:0]           adj_waddr, adj_raddr, cnt_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [COUNT_BITS-1:0]   cnt_wdata;

  logic [NW-1:0]         n_eff;
  logic [WLEN_W-1:0]     wlen_eff;
  logic                  a_ok, b_ok, step_done, out_free, clr_last, mod_last, last_chunk;
  kind_e                 kind_in;
  logic [CHUNK-1:0]      chunk_mask;
  logic [PCW-1:0]        chunk_cnt, run;
  logic [KW-1:0]         sel_k;
  logic                  sel_found, hit;
  logic [NW-1:0]         pick_tgt, deg_fin;
  logic [RW-1:0]         rem_sh, rem_nxt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [63:0]           res_ext;
  logic [OCOUNT_W-1:0]   res_sat;
  logic [VW-1:0]         pick_vtx;

  // effective register values
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_q);
    end
    wlen_eff = (wlen_q == '0) ? WLEN_W'(1) : wlen_q;
  end

  assign kind_in    = kind_e'(kind_i);
  assign a_ok       = 32'(vertex_a_i) < 32'(n_eff);
  assign b_ok       = 32'(vertex_b_i) < 32'(n_eff);
  assign step_done  = (22'(steps_q) + 22'd1) >= 22'(wlen_eff);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = clr_addr_q == VW'(MAX_VERTICES - 1);
  assign mod_last   = bit_cnt_q == IW'(RAND_W - 1);
  assign last_chunk = (32'(base_q) + 32'(CHUNK)) >= 32'(n_eff);

  // one chunk of the adjacency row: masked bits, their count, and the wanted neighbor
  always_comb begin
    chunk_mask = '0;
    chunk_cnt  = '0;
    run        = '0;
    sel_k      = '0;
    sel_found  = 1'b0;
    pick_tgt   = NW'(rem_q) - seen_q;
    for (int k = 0; k < CHUNK; k++) begin
      chunk_mask[k] = row_q[k] && ((32'(base_q) + 32'(k)) < 32'(n_eff));
    end
    for (int k = 0; k < CHUNK; k++) begin
      chunk_cnt = chunk_cnt + PCW'(chunk_mask[k]);
    end
    for (int k = 0; k < CHUNK; k++) begin
      if (chunk_mask[k] && !sel_found && (32'(run) == 32'(pick_tgt))) begin
        sel_found = 1'b1;
        sel_k     = KW'(k);
      end
      if (chunk_mask[k]) begin
        run = run + PCW'(1);
      end
    end
  end

  assign hit      = (32'(seen_q) + 32'(chunk_cnt)) > 32'(rem_q);
  assign deg_fin  = deg_q + NW'(chunk_cnt);
  assign pick_vtx = VW'(base_q) + VW'(sel_k);

  // restoring remainder step
  assign rem_sh  = {rem_q[RW-2:0], dividend_q[RAND_W-1]};
  assign rem_nxt = (rem_sh >= RW'(div_q)) ? (rem_sh - RW'(div_q)) : rem_sh;

  assign cnt_inc = (cnt_rdata_q == '1) ? cnt_rdata_q : (cnt_rdata_q + CNT_ONE);
  assign res_ext = 64'(res_count_q);
  assign res_sat = (res_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : res_ext[OCOUNT_W-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_in)
            KIND_ADD_EDGE: state_d = (a_ok && b_ok) ? S_E_RD : S_CRD;
            KIND_START:    state_d = a_ok ? S_CLEAR : S_CRD;
            KIND_STEP:     state_d = S_STEP;
            KIND_READ:     state_d = a_ok ? S_CRD : S_FIN;
          endcase
        end
      end
      S_CLEAR: if (clr_last) state_d = clr_all_q ? S_IDLE : S_FIN;
      S_E_RD:  state_d = S_E_WA;
      S_E_WA:  state_d = S_E_WB;
      S_E_WB:  state_d = S_CRD;
      S_STEP:  state_d = step_done ? S_CRD : S_DEG;
      S_DEG:   if (last_chunk) state_d = S_MOD;
      S_MOD: begin
        if (mod_last) state_d = (deg_q == '0) ? S_CRD : S_PICK;
      end
      S_PICK:  if (hit) state_d = S_CRD;
      S_CRD:   state_d = S_CUSE;
      S_CUSE:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = clr_addr_q;
    adj_wdata = '0;
    adj_raddr = cur_q;
    cnt_we    = 1'b0;
    cnt_waddr = rep_q;
    cnt_wdata = cnt_inc;
    unique case (state_q)
      S_CLEAR: begin
        adj_we    = clr_all_q;
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_q;
        cnt_wdata = (!clr_all_q && clr_addr_q == cur_q) ? CNT_ONE : '0;
      end
      S_E_RD: adj_raddr = VW'(a_q);
      S_E_WA: begin
        adj_raddr = VW'(b_q);
        adj_we    = 1'b1;
        adj_waddr = VW'(a_q);
        adj_wdata = adj_rdata_q | (ROW_ONE << b_q);
      end
      S_E_WB: begin
        adj_we    = 1'b1;
        adj_waddr = VW'(b_q);
        adj_wdata = adj_rdata_q | (ROW_ONE << a_q);
      end
      S_CUSE: cnt_we = bump_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
    cnt_rdata_q <= cnt_mem[rep_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      vcount_q    <= VCOUNT_W'(1);
      wlen_q      <= WLEN_W'(1);
      cur_q       <= '0;
      steps_q     <= '0;
      a_q         <= '0;
      b_q         <= '0;
      dividend_q  <= '0;
      status_q    <= STATUS_OK;
      res_count_q <= '0;
      bump_q      <= 1'b0;
      clr_all_q   <= 1'b1;
      clr_addr_q  <= '0;
      rep_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      deg_q       <= '0;
      seen_q      <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      vertex_q    <= '0;
      visit_q     <= '0;
      ostat_q     <= STATUS_OK;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_VERTEX_COUNT: vcount_q <= cfg_data_i[VCOUNT_W-1:0];
          CFG_WALK_LENGTH:  wlen_q   <= cfg_data_i;
        endcase
      end

      // in S_FIN the output register is reloaded below whenever it frees up
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            a_q        <= vertex_a_i;
            b_q        <= vertex_b_i;
            dividend_q <= random_value_i;
            bump_q     <= 1'b0;
            unique case (kind_in)
              KIND_ADD_EDGE: begin
                rep_q    <= cur_q;
                status_q <= (a_ok && b_ok) ? STATUS_OK : STATUS_RANGE;
              end
              KIND_START: begin
                rep_q    <= cur_q;
                status_q <= a_ok ? STATUS_OK : STATUS_RANGE;
                if (a_ok) begin
                  cur_q      <= VW'(vertex_a_i);
                  steps_q    <= '0;
                  clr_all_q  <= 1'b0;
                  clr_addr_q <= '0;
                end
              end
              KIND_STEP: begin
                rep_q    <= cur_q;
                status_q <= STATUS_OK;
              end
              KIND_READ: begin
                if (a_ok) begin
                  rep_q    <= VW'(vertex_a_i);
                  status_q <= STATUS_OK;
                end else begin
                  rep_q       <= cur_q;
                  status_q    <= STATUS_RANGE;
                  res_count_q <= '0;
                end
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_last) begin
            clr_addr_q  <= '0;
            res_count_q <= CNT_ONE;
          end else begin
            clr_addr_q <= clr_addr_q + VW'(1);
          end
        end
        S_STEP: begin
          if (step_done) begin
            status_q <= STATUS_DONE;
          end else begin
            row_q  <= PW'(adj_rdata_q);
            base_q <= '0;
            deg_q  <= '0;
          end
        end
        S_DEG: begin
          row_q  <= row_q >> CHUNK;
          base_q <= base_q + BW'(CHUNK);
          deg_q  <= deg_fin;
          if (last_chunk) begin
            // no neighbor in range: jump to random mod vertex count
            div_q     <= (deg_fin == '0) ? n_eff : deg_fin;
            rem_q     <= '0;
            bit_cnt_q <= '0;
          end
        end
        S_MOD: begin
          rem_q      <= rem_nxt;
          dividend_q <= dividend_q << 1;
          bit_cnt_q  <= bit_cnt_q + IW'(1);
          if (mod_last) begin
            if (deg_q == '0) begin
              cur_q   <= VW'(rem_nxt);
              rep_q   <= VW'(rem_nxt);
              steps_q <= steps_q + WLEN_W'(1);
              bump_q  <= 1'b1;
            end else begin
              row_q  <= PW'(adj_rdata_q);
              base_q <= '0;
              seen_q <= '0;
            end
          end
        end
        S_PICK: begin
          if (hit) begin
            cur_q   <= pick_vtx;
            rep_q   <= pick_vtx;
            steps_q <= steps_q + WLEN_W'(1);
            bump_q  <= 1'b1;
          end else begin
            row_q  <= row_q >> CHUNK;
            base_q <= base_q + BW'(CHUNK);
            seen_q <= seen_q + NW'(chunk_cnt);
          end
        end
        S_CUSE: begin
          res_count_q <= bump_q ? cnt_inc : cnt_rdata_q;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            vertex_q    <= VERTEX_W'(cur_q);
            visit_q     <= res_sat;
            ostat_q     <= status_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign vertex_o      = vertex_q;
  assign visit_count_o = visit_q;
  assign status_o      = ostat_q;

endmodule

// ===== rtl/core/rwvc_checker.sv =====
// port-level checks for the random walk visit counter, bound to the top level
module rwvc_checker
  import rwvc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [VERTEX_W-1:0] vertex_o,
  input logic [OCOUNT_W-1:0] visit_count_o,
  input logic [1:0]          status_o
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_o)
      && $stable(visit_count_o) && $stable(status_o))
    else $error("held result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STATUS_OK || status_o == STATUS_RANGE
      || status_o == STATUS_DONE)
    else $error("bad status code");

  // the clearing pass is still running when reset is released
  assert property (@(posedge clk_i) $rose(rst_ni) |-> in_stall_o)
    else $error("request taken right after reset");

  // every accepted request leaves the sequencer busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer not busy after request");

endmodule

bind random_walk_visit_counter_core rwvc_checker u_rwvc_checker (.*);
